[rtl/dfca_pkg.sv]
// Shared widths, codes and control types of the dual free-list chunk allocator.
package dfca_pkg;

  localparam int unsigned CHUNK_COUNT_DEF = 256;
  localparam int unsigned CMD_W           = 3;
  localparam int unsigned CNT_W           = 24;
  localparam int unsigned CHUNK_W         = 8;
  localparam int unsigned STATUS_W        = 2;
  localparam int unsigned CAP_W           = 24;
  localparam logic [CAP_W-1:0] CAP_RESET  = 24'd1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_DESC_ALLOC = 3'd0,
    CMD_DATA_ALLOC = 3'd1,
    CMD_DATA_ZALLOC = 3'd2,
    CMD_DESC_FREE  = 3'd3,
    CMD_DATA_FREE  = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_TOO_BIG = 2'd2
  } status_e;

  // Per-cycle operation on one pool
  typedef struct packed {
    logic init;  // write addr+1 into the link at addr (clearing pass)
    logic rd;    // read the link of the current head
    logic pop;   // load head from the link read last cycle
    logic push;  // link addr to head, make addr the new head
  } pool_cmd_t;

endpackage

[rtl/dfca_if.sv]
// Request and response channel interfaces of the chunk allocator.
interface dfca_req_if;
  import dfca_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [CNT_W-1:0]   element_count;
  logic [CHUNK_W-1:0] freed_chunk;

  modport source (output valid, command, element_count, freed_chunk, input ready);
  modport sink   (input valid, command, element_count, freed_chunk, output ready);
endinterface

interface dfca_rsp_if;
  import dfca_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CHUNK_W-1:0]  granted_chunk;
  logic                clear_needed;

  modport source (output valid, status, granted_chunk, clear_needed, input ready);
  modport sink   (input valid, status, granted_chunk, clear_needed, output ready);
endinterface

[rtl/dual_free_list_chunk_allocator_unit.sv]
// Dual free-list chunk allocator: descriptor and data pools of CHUNK_COUNT chunks each,
// managed as LIFO lists whose next links live in one synchronous RAM per pool. After
// reset the block runs a clearing pass over every chunk index that links both tables in
// index order; no request is taken during it, while capacity writes are taken at any time.
// Then each request yields exactly one response. A successful allocate passes through
// S_IDLE and S_POP: the link of the head chunk is read from the pool's RAM into its read
// register and becomes the new head. Frees, failed allocates and unused commands are
// answered from S_IDLE. A finished response sits in an output register, and the next
// request is taken in the cycle that register is drained. Frees of an index at or above
// CHUNK_COUNT are dropped, and double frees are not detected.
module dual_free_list_chunk_allocator_unit #(
  parameter int unsigned CHUNK_COUNT = dfca_pkg::CHUNK_COUNT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dfca_pkg::CAP_W-1:0]  cfg_wdata_i,
  dfca_req_if.sink                    req_i,
  dfca_rsp_if.source                  rsp_o
);
  import dfca_pkg::*;

  localparam int unsigned IDX_W  = $clog2(CHUNK_COUNT);
  localparam int unsigned LINK_W = $clog2(CHUNK_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHUNK_COUNT - 1);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_POP
  } state_e;

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     init_cnt_q, init_cnt_d;
  logic                 pop_data_q, pop_data_d;
  logic                 pop_clear_q, pop_clear_d;
  logic                 out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]  status_q, status_d;
  logic [CHUNK_W-1:0]   granted_q, granted_d;
  logic                 clear_q, clear_d;
  logic [CAP_W-1:0]     cap_q;

  pool_cmd_t            desc_cmd, data_cmd;
  logic [IDX_W-1:0]     pool_addr;
  logic [LINK_W-1:0]    desc_head, data_head;
  logic                 desc_empty, data_empty;

  logic                 slot_free;
  logic                 req_fire;
  logic                 freed_in_range;
  logic                 sel_empty;
  logic [LINK_W-1:0]    pop_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  assign slot_free      = !out_valid_q || rsp_o.ready;
  assign req_i.ready    = (state_q == S_IDLE) && slot_free;
  assign req_fire       = req_i.valid && req_i.ready;
  assign freed_in_range = ({{(32-CHUNK_W){1'b0}}, req_i.freed_chunk} < 32'(CHUNK_COUNT));
  assign pop_head       = pop_data_q ? data_head : desc_head;

  always_comb begin
    state_d     = state_q;
    init_cnt_d  = init_cnt_q;
    pop_data_d  = pop_data_q;
    pop_clear_d = pop_clear_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    status_d    = status_q;
    granted_d   = granted_q;
    clear_d     = clear_q;
    desc_cmd    = '0;
    data_cmd    = '0;
    pool_addr   = IDX_W'(req_i.freed_chunk);
    sel_empty   = desc_empty;

    case (state_q)
      S_INIT: begin
        pool_addr     = init_cnt_q;
        desc_cmd.init = 1'b1;
        data_cmd.init = 1'b1;
        init_cnt_d    = init_cnt_q + IDX_W'(1);
        if (init_cnt_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_fire) begin
          // default response for frees and unused commands
          out_valid_d = 1'b1;
          status_d    = ST_OK;
          granted_d   = '0;
          clear_d     = 1'b0;
          case (req_i.command)
            CMD_DESC_ALLOC, CMD_DATA_ALLOC, CMD_DATA_ZALLOC: begin
              pop_data_d  = (req_i.command != CMD_DESC_ALLOC);
              pop_clear_d = (req_i.command == CMD_DATA_ZALLOC);
              sel_empty   = (req_i.command == CMD_DESC_ALLOC) ? desc_empty : data_empty;
              if (sel_empty) begin
                status_d = ST_EMPTY;
              end else if (req_i.element_count > cap_q) begin
                status_d = ST_TOO_BIG;
              end else begin
                // hold the response until the head link comes back
                out_valid_d = 1'b0;
                if (req_i.command == CMD_DESC_ALLOC) begin
                  desc_cmd.rd = 1'b1;
                end else begin
                  data_cmd.rd = 1'b1;
                end
                state_d = S_POP;
              end
            end
            CMD_DESC_FREE: begin
              desc_cmd.push = freed_in_range;
            end
            CMD_DATA_FREE: begin
              data_cmd.push = freed_in_range;
            end
            default: begin
            end
          endcase
        end
      end

      S_POP: begin
        if (pop_data_q) begin
          data_cmd.pop = 1'b1;
        end else begin
          desc_cmd.pop = 1'b1;
        end
        out_valid_d = 1'b1;
        status_d    = ST_OK;
        granted_d   = CHUNK_W'(pop_head[IDX_W-1:0]);
        clear_d     = pop_clear_q;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_cnt_q  <= '0;
      pop_data_q  <= 1'b0;
      pop_clear_q <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      granted_q   <= '0;
      clear_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_cnt_q  <= init_cnt_d;
      pop_data_q  <= pop_data_d;
      pop_clear_q <= pop_clear_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      granted_q   <= granted_d;
      clear_q     <= clear_d;
    end
  end

  dfca_pool #(
    .CHUNK_COUNT (CHUNK_COUNT)
  ) u_desc_pool (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (desc_cmd),
    .addr_i  (pool_addr),
    .head_o  (desc_head),
    .empty_o (desc_empty)
  );

  dfca_pool #(
    .CHUNK_COUNT (CHUNK_COUNT)
  ) u_data_pool (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (data_cmd),
    .addr_i  (pool_addr),
    .head_o  (data_head),
    .empty_o (data_empty)
  );

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = status_q;
  assign rsp_o.granted_chunk = granted_q;
  assign rsp_o.clear_needed  = clear_q;

endmodule

[rtl/dfca_link_ram.sv]
// Single-port-write, single-port-read link RAM with registered read data.
module dfca_link_ram #(
  parameter int unsigned DEPTH  = dfca_pkg::CHUNK_COUNT_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH),
  parameter int unsigned DATA_W = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/dfca_pool.sv]
// One free-list pool: head register plus its next-link RAM.
module dfca_pool #(
  parameter int unsigned CHUNK_COUNT = dfca_pkg::CHUNK_COUNT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dfca_pkg::pool_cmd_t                cmd_i,
  input  logic [$clog2(CHUNK_COUNT)-1:0]     addr_i,
  output logic [$clog2(CHUNK_COUNT+1)-1:0]   head_o,
  output logic                               empty_o
);
  import dfca_pkg::*;

  localparam int unsigned IDX_W  = $clog2(CHUNK_COUNT);
  localparam int unsigned LINK_W = $clog2(CHUNK_COUNT + 1);
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(CHUNK_COUNT);

  logic [LINK_W-1:0] head_q, head_d;
  logic              ram_we;
  logic [LINK_W-1:0] ram_wdata;
  logic [LINK_W-1:0] ram_rdata;

  assign ram_we    = cmd_i.init | cmd_i.push;
  assign ram_wdata = cmd_i.init ? (LINK_W'(addr_i) + LINK_W'(1)) : head_q;

  dfca_link_ram #(
    .DEPTH  (CHUNK_COUNT),
    .ADDR_W (IDX_W),
    .DATA_W (LINK_W)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_i),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd),
    .raddr_i (head_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    head_d = head_q;
    if (cmd_i.pop) begin
      head_d = ram_rdata;
    end else if (cmd_i.push) begin
      head_d = LINK_W'(addr_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else begin
      head_q <= head_d;
    end
  end

  assign head_o  = head_q;
  assign empty_o = (head_q == LINK_NULL);

endmodule
